@@ rtl/core/lds_pkg.sv @@
// ----------------------------------------------------------------------------
// Laplacian diffusion stencil package
// Shared sizes, register codes and the types that travel between the
// row store, the rate pipeline and the top level.
// ----------------------------------------------------------------------------
package lds_pkg;

	// Grid limits and the index widths that follow from them.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_DIM    = 2;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// Field widths of the channels and the configuration port.
	localparam int ELEV_W     = 32;
	localparam int RATE_W     = 48;
	localparam int IDX_W      = 10;
	localparam int DIM_W      = 11;
	localparam int COEF_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Reset values of the configuration registers.
	localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(1024);
	localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(32'h0100_0000);

	// Arithmetic widths: a second difference of three samples, a product with
	// one half of a coefficient, the sum of two products and the full sum.
	localparam int DIFF_W = ELEV_W + 2;
	localparam int HALF_W = COEF_W / 2;
	localparam int PROD_W = DIFF_W + HALF_W + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int TOT_W  = SUM_W + HALF_W;
	localparam int FRAC_W = 24;

	// Result queue.
	localparam int RES_DEPTH = 8;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_COEF_X      = 2'd2,
		REG_COEF_Y      = 2'd3
	} cfg_reg_t;

	// Last column and last row of the grid in use.
	typedef struct packed {
		logic [COL_W-1:0] col_last;
		logic [ROW_W-1:0] row_last;
	} geom_t;

	// One stencil job: both second differences and the cell tags.
	typedef struct packed {
		logic signed [DIFF_W-1:0] ddx;
		logic signed [DIFF_W-1:0] ddy;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic                     last;
	} job_t;

	// One finished result.
	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last;
	} res_t;

endpackage

@@ rtl/core/lds_if.sv @@
// ----------------------------------------------------------------------------
// Laplacian diffusion stencil channels
// Valid/ready channels for the elevation samples and for the results.
// ----------------------------------------------------------------------------
interface lds_sample_if import lds_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ELEV_W-1:0] elevation;

	modport source (output valid, output elevation, input ready);
	modport sink (input valid, input elevation, output ready);
endinterface

interface lds_result_if import lds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] rate;
	logic [IDX_W-1:0]  row_index;
	logic [IDX_W-1:0]  col_index;
	logic              frame_last;

	modport source (output valid, output rate, output row_index, output col_index,
		output frame_last, input ready);
	modport sink (input valid, input rate, input row_index, input col_index,
		input frame_last, output ready);
endinterface

@@ rtl/core/lds_row_store.sv @@
// ----------------------------------------------------------------------------
// Laplacian diffusion stencil row store
// Holds the two previous rows in synchronous memories, reads the neighbors
// of each sample, writes the rows back and expands every sample into its
// stencil jobs, which leave one per cycle while the rate pipeline takes them.
// ----------------------------------------------------------------------------
module lds_row_store import lds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  geom_t geom,
	lds_sample_if.sink sample,
	output job_t  job,
	output logic  job_valid,
	input  logic  job_ready
);

	// Row two above (a) and the row just above (b) the incoming sample.
	logic [ELEV_W-1:0] mem_a [MAX_WIDTH];
	logic [ELEV_W-1:0] mem_b [MAX_WIDTH];

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              accept;
	logic              last_col;
	logic              last_row;

	logic              s1_valid;
	logic              s1_fire;
	logic [ELEV_W-1:0] x_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              lcol_s1;
	logic              lrow_s1;
	logic [ELEV_W-1:0] a_rd_s1;
	logic [ELEV_W-1:0] bc_rd_s1;
	logic [ELEV_W-1:0] bn_rd_s1;
	logic              byp_c_s1;
	logic              byp_n_s1;
	logic [ELEV_W-1:0] byp_a_data_s1;
	logic [ELEV_W-1:0] byp_x_data_s1;
	logic [ELEV_W-1:0] a_fwd;
	logic [ELEV_W-1:0] bc_fwd;
	logic [ELEV_W-1:0] bn_fwd;

	logic [ELEV_W-1:0] win0_q;
	logic [ELEV_W-1:0] win1_q;
	logic [ELEV_W-1:0] prevb_q;

	logic [ELEV_W-1:0] up0;
	logic [ELEV_W-1:0] lf_pre;
	logic [ELEV_W-1:0] rt_pre;
	logic [ELEV_W-1:0] lf0;
	logic [ELEV_W-1:0] rt0;
	logic [ELEV_W-1:0] lf1;
	job_t              new_jobs [3];
	logic [2:0]        new_mask;

	job_t              jobs_s2 [3];
	logic [2:0]        mask_s2;
	logic [2:0]        issue_sel;
	logic              issue;
	logic              s2_free;

	// Twice the center minus both neighbors, formed exactly.
	function automatic logic signed [DIFF_W-1:0] second_diff(
		input logic [ELEV_W-1:0] ctr,
		input logic [ELEV_W-1:0] na,
		input logic [ELEV_W-1:0] nb
	);
		logic signed [DIFF_W-1:0] c2;
		logic signed [DIFF_W-1:0] ae;
		logic signed [DIFF_W-1:0] be;
		c2 = signed'({ctr[ELEV_W-1], ctr, 1'b0});
		ae = signed'({{2{na[ELEV_W-1]}}, na});
		be = signed'({{2{nb[ELEV_W-1]}}, nb});
		return c2 - ae - be;
	endfunction

	// Position of the incoming sample in the grid.
	assign accept   = sample.valid && sample.ready;
	assign last_col = col_q >= geom.col_last;
	assign last_row = row_q >= geom.row_last;

	// Stage one moves on when the job stage can take its jobs.
	assign s1_fire      = s1_valid && s2_free;
	assign sample.ready = !s1_valid || s1_fire;

	// A write in the same cycle as the read of the next sample is forwarded.
	assign a_fwd  = byp_c_s1 ? byp_a_data_s1 : a_rd_s1;
	assign bc_fwd = byp_c_s1 ? byp_x_data_s1 : bc_rd_s1;
	assign bn_fwd = byp_n_s1 ? byp_x_data_s1 : bn_rd_s1;

	// Memory a: read the cell above-above, write back the row that moves up.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			mem_a[col_s1] <= bc_fwd;
		end
		if (accept) begin
			a_rd_s1 <= mem_a[col_q];
		end
	end

	// Memory b: read the cell above and its right neighbor, write the sample.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			mem_b[col_s1] <= x_s1;
		end
		if (accept) begin
			bc_rd_s1 <= mem_b[col_q];
			bn_rd_s1 <= mem_b[col_q + COL_W'(1)];
		end
	end

	// Stage one payload and forwarding marks.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1          <= sample.elevation;
			col_s1        <= col_q;
			row_s1        <= row_q;
			lcol_s1       <= last_col;
			lrow_s1       <= last_row;
			byp_c_s1      <= s1_fire && (col_s1 == col_q);
			byp_n_s1      <= s1_fire && (col_s1 == col_q + COL_W'(1));
			byp_a_data_s1 <= bc_fwd;
			byp_x_data_s1 <= x_s1;
		end
		if (s1_fire) begin
			prevb_q <= bc_fwd;
			jobs_s2 <= new_jobs;
		end
	end

	// Build the up to three jobs that one sample releases.
	always_comb begin
		// Cell of the row above, mirrored at the left, right and top edges.
		up0    = (row_s1 == ROW_W'(1)) ? x_s1 : a_fwd;
		rt_pre = lcol_s1 ? '0 : bn_fwd;
		lf_pre = (col_s1 != '0) ? prevb_q : '0;
		lf0    = (col_s1 == '0) ? rt_pre : lf_pre;
		rt0    = lcol_s1 ? lf0 : rt_pre;
		new_jobs[0].ddx  = second_diff(bc_fwd, lf0, rt0);
		new_jobs[0].ddy  = second_diff(bc_fwd, up0, x_s1);
		new_jobs[0].row  = IDX_W'(row_s1 - ROW_W'(1));
		new_jobs[0].col  = IDX_W'(col_s1);
		new_jobs[0].last = 1'b0;

		// Bottom row: the cell to the left of the sample, mirrored below.
		lf1 = (col_s1 == COL_W'(1)) ? x_s1 : win1_q;
		new_jobs[1].ddx  = second_diff(win0_q, lf1, x_s1);
		new_jobs[1].ddy  = second_diff(win0_q, prevb_q, prevb_q);
		new_jobs[1].row  = IDX_W'(row_s1);
		new_jobs[1].col  = IDX_W'(col_s1 - COL_W'(1));
		new_jobs[1].last = 1'b0;

		// Bottom right corner: the sample itself closes the grid.
		new_jobs[2].ddx  = second_diff(x_s1, win0_q, win0_q);
		new_jobs[2].ddy  = second_diff(x_s1, bc_fwd, bc_fwd);
		new_jobs[2].row  = IDX_W'(row_s1);
		new_jobs[2].col  = IDX_W'(col_s1);
		new_jobs[2].last = 1'b1;

		new_mask = {lrow_s1 && lcol_s1, lrow_s1 && (col_s1 != '0), row_s1 != '0};
	end

	// Jobs leave in order, lowest pending slot first.
	assign issue_sel = mask_s2 & (~mask_s2 + 3'd1);
	assign job_valid = |mask_s2;
	assign issue     = job_valid && job_ready;
	assign s2_free   = (mask_s2 == 3'd0) ||
		(issue && ((mask_s2 & (mask_s2 - 3'd1)) == 3'd0));

	always_comb begin
		if (mask_s2[0]) begin
			job = jobs_s2[0];
		end else if (mask_s2[1]) begin
			job = jobs_s2[1];
		end else begin
			job = jobs_s2[2];
		end
	end

	// Counters, window, stage valid and pending jobs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			s1_valid <= 1'b0;
			mask_s2  <= '0;
			win0_q   <= '0;
			win1_q   <= '0;
		end else begin
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_fire) begin
				s1_valid <= 1'b0;
			end
			if (s1_fire) begin
				mask_s2 <= new_mask;
				win0_q  <= x_s1;
				win1_q  <= win0_q;
			end else if (issue) begin
				mask_s2 <= mask_s2 & ~issue_sel;
			end
		end
	end

endmodule

@@ rtl/core/lds_rate_pipe.sv @@
// ----------------------------------------------------------------------------
// Laplacian diffusion stencil rate pipeline
// Weights the second differences with the coefficients, drops the fraction
// bits, clamps negative terms to zero and queues the results. Jobs are
// taken only while the queue has room for everything in flight.
// ----------------------------------------------------------------------------
module lds_rate_pipe import lds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  job_t              job,
	input  logic              job_valid,
	output logic              job_ready,
	input  logic [COEF_W-1:0] coef_x,
	input  logic [COEF_W-1:0] coef_y,
	lds_result_if.source result
);

	logic [RES_CNT_W-1:0]     occ_q;
	logic                     issue;
	logic                     pop;

	logic                     v_s1;
	logic signed [PROD_W-1:0] pxh_s1;
	logic signed [PROD_W-1:0] pxl_s1;
	logic signed [PROD_W-1:0] pyh_s1;
	logic signed [PROD_W-1:0] pyl_s1;
	logic [IDX_W-1:0]         row_s1;
	logic [IDX_W-1:0]         col_s1;
	logic                     last_s1;

	logic                     v_s2;
	logic signed [SUM_W-1:0]  hi_s2;
	logic signed [SUM_W-1:0]  lo_s2;
	logic [IDX_W-1:0]         row_s2;
	logic [IDX_W-1:0]         col_s2;
	logic                     last_s2;

	logic signed [TOT_W-1:0]  total;
	logic [RATE_W-1:0]        rate_val;

	res_t                     fifo_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]     wr_ptr_q;
	logic [RES_PTR_W-1:0]     rd_ptr_q;
	logic [RES_CNT_W-1:0]     cnt_q;

	// Credit check covers the queue and both pipeline stages.
	assign job_ready = occ_q < RES_CNT_W'(RES_DEPTH);
	assign issue     = job_valid && job_ready;
	assign pop       = result.valid && result.ready;

	// Stage one: each coefficient is split in halves of 16 bits.
	always_ff @(posedge clk) begin
		if (issue) begin
			pxh_s1  <= job.ddx * signed'({1'b0, coef_x[COEF_W-1:HALF_W]});
			pxl_s1  <= job.ddx * signed'({1'b0, coef_x[HALF_W-1:0]});
			pyh_s1  <= job.ddy * signed'({1'b0, coef_y[COEF_W-1:HALF_W]});
			pyl_s1  <= job.ddy * signed'({1'b0, coef_y[HALF_W-1:0]});
			row_s1  <= job.row;
			col_s1  <= job.col;
			last_s1 <= job.last;
		end
	end

	// Stage two: sum the high halves and the low halves.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			hi_s2   <= SUM_W'(pxh_s1) + SUM_W'(pyh_s1);
			lo_s2   <= SUM_W'(pxl_s1) + SUM_W'(pyl_s1);
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
		end
	end

	// Full sum, floor shift and clamp at zero. The positive quotient holds at
	// most 43 bits, so it never reaches the top of the rate range.
	always_comb begin
		total = (TOT_W'(hi_s2) <<< HALF_W) + TOT_W'(lo_s2);
		if (total[TOT_W-1] || (total[TOT_W-2:FRAC_W] == '0)) begin
			rate_val = '0;
		end else begin
			rate_val = RATE_W'(total[TOT_W-2:FRAC_W]);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (v_s2) begin
			fifo_q[wr_ptr_q] <= '{rate: rate_val, row: row_s2, col: col_s2, last: last_s2};
		end
	end

	assign result.valid      = cnt_q != '0;
	assign result.rate       = fifo_q[rd_ptr_q].rate;
	assign result.row_index  = fifo_q[rd_ptr_q].row;
	assign result.col_index  = fifo_q[rd_ptr_q].col;
	assign result.frame_last = fifo_q[rd_ptr_q].last;

	// Stage valids, pointers and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			occ_q    <= '0;
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			v_s1  <= issue;
			v_s2  <= v_s1;
			occ_q <= occ_q + RES_CNT_W'(issue) - RES_CNT_W'(pop);
			cnt_q <= cnt_q + RES_CNT_W'(v_s2) - RES_CNT_W'(pop);
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/laplacian_diffusion_stencil_core.sv @@
// ----------------------------------------------------------------------------
// Laplacian diffusion stencil core
// Five-point diffusion term of a streamed elevation grid with mirrored
// edges: coef_x*(2c-left-right) + coef_y*(2c-up-down), 24 fraction bits
// dropped, negative terms clamped to zero.
//
// Usage: set grid_width, grid_height, coef_x and coef_y through the write
// port while the block is idle, then send the grid in raster order on the
// sample channel. Sizes act clamped to the range 2 to 1024.
// The result of a cell in row r-1 leaves when the sample below it is taken;
// on the last row each sample also releases the cell to its left, and the
// final sample releases itself with frame_last set. The counters then wrap.
// Throughput: one sample per cycle; a last-row sample that releases two or three
// results stalls the sample channel while the rate pipeline starts one a cycle.
// An eight-entry result queue with credit flow control sits in front of the
// result channel; when the receiver stalls the queue fills and then the
// sample channel stalls, with nothing lost.
// Reset sets the registers to 1024, 1024, 1.0 and 1.0 and starts a new grid.
// The row memories need no clearing pass.
// ----------------------------------------------------------------------------
module laplacian_diffusion_stencil_core import lds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	lds_sample_if.sink            sample,
	lds_result_if.source          result
);

	logic [DIM_W-1:0]  grid_width_q;
	logic [DIM_W-1:0]  grid_height_q;
	logic [COEF_W-1:0] coef_x_q;
	logic [COEF_W-1:0] coef_y_q;
	logic [DIM_W-1:0]  width_eff;
	logic [DIM_W-1:0]  height_eff;
	geom_t             geom;
	job_t              job;
	logic              job_valid;
	logic              job_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_RESET;
			grid_height_q <= DIM_RESET;
			coef_x_q      <= COEF_RESET;
			coef_y_q      <= COEF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata[DIM_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_wdata[DIM_W-1:0];
				REG_COEF_X:      coef_x_q      <= cfg_wdata[COEF_W-1:0];
				REG_COEF_Y:      coef_y_q      <= cfg_wdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// Grid size as used, and the last column and row that follow from it.
	always_comb begin
		if (grid_width_q < DIM_W'(MIN_DIM)) begin
			width_eff = DIM_W'(MIN_DIM);
		end else if (grid_width_q > DIM_W'(MAX_WIDTH)) begin
			width_eff = DIM_W'(MAX_WIDTH);
		end else begin
			width_eff = grid_width_q;
		end
		if (grid_height_q < DIM_W'(MIN_DIM)) begin
			height_eff = DIM_W'(MIN_DIM);
		end else if (grid_height_q > DIM_W'(MAX_HEIGHT)) begin
			height_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			height_eff = grid_height_q;
		end
		geom.col_last = COL_W'(width_eff - DIM_W'(1));
		geom.row_last = ROW_W'(height_eff - DIM_W'(1));
	end

	lds_row_store u_row_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.sample    (sample),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready)
	);

	lds_rate_pipe u_rate_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.coef_x    (coef_x_q),
		.coef_y    (coef_y_q),
		.result    (result)
	);

endmodule
